// ===== design/sbda_pkg.sv =====
package sbda_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 6;
  localparam int NUM_DIGITS  = 10;               // 4294967295 has ten digits
  localparam int DIGIT_IDX_W = 4;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int CNT_W       = 5;                // one shift per magnitude bit

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

endpackage

// ===== design/sbda_front.sv =====
module sbda_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sbda_pkg::VALUE_W-1:0]        in_tdata,
  input  logic                                q_full,
  output logic                                q_push,
  output sbda_pkg::item_t                     q_item
);
  import sbda_pkg::*;

  logic neg;

  assign neg       = in_tdata[VALUE_W-1];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // unsigned negate also gives the true magnitude of the most negative value
  assign q_item.neg = neg;
  assign q_item.mag = neg ? (~in_tdata + VALUE_W'(1)) : in_tdata;

endmodule

// ===== design/sbda_queue.sv =====
module sbda_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sbda_pkg::item_t push_item,
  input  logic            pop,
  output sbda_pkg::item_t head_item,
  output logic            full,
  output logic            empty
);
  import sbda_pkg::*;

  item_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign empty     = (count_r == '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/sbda_back.sv =====
module sbda_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  sbda_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sbda_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);
  import sbda_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  state_t                         state_r, state_nxt;
  logic [VALUE_W-1:0]             bin_r, bin_nxt;
  digit_t [NUM_DIGITS-1:0]        bcd_r, bcd_nxt;
  logic                           neg_r, neg_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [DIGIT_IDX_W-1:0]         dig_r, dig_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]              char_r, char_nxt;
  logic                           last_r, last_nxt;

  digit_t [NUM_DIGITS-1:0]        bcd_adj;
  logic [BCD_W:0]                 bcd_shift;
  logic [DIGIT_IDX_W-1:0]         lead;
  logic                           emit_ok;

  assign out_tvalid = out_valid_r;
  assign out_char   = char_r;
  assign out_last   = last_r;
  assign emit_ok    = !out_valid_r || out_tready;

  // shift-and-add-3: correct each digit, then shift in the next magnitude bit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_shift = {bcd_adj, bin_r[VALUE_W-1]};
  end

  // most significant non-zero digit, or the units digit for zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        lead = DIGIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          bin_nxt   = q_item.mag;
          neg_nxt   = q_item.neg;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = bcd_shift[BCD_W-1:0];
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        dig_nxt   = lead;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            char_nxt = CHAR_MINUS;
            last_nxt = 1'b0;
            neg_nxt  = 1'b0;
          end else begin
            char_nxt = CHAR_ZERO + {2'b00, bcd_r[dig_r]};
            last_nxt = (dig_r == '0);
            if (dig_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              dig_nxt = dig_r - DIGIT_IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    dig_r  <= dig_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== design/signed_binary_to_decimal_ascii_core.sv =====
// Channel  Dir  Port group        Contents
// in       in   in_tvalid/tready  in_tdata[31:0]: value (signed)
// out      out  out_tvalid/tready out_tdata[5:0]: character, [7:6] zero; out_tlast: last
//
// Per number: dequeue, shift-and-add-3 conversion with one shift per magnitude bit,
// find the leading digit, then one character per cycle (1 to 11 characters)
// while the output is not stalled.
// A two-entry queue keeps taking numbers while the converter is busy.
// Reset (rst_n low, synchronous) empties the queue and drops any pending output.
// An output stall holds the converter in its emit phase; the queue fills behind it.
module signed_binary_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] character, [7:6] zero
  output logic        out_tlast
);
  import sbda_pkg::*;

  item_t             push_item;
  item_t             head_item;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [CHAR_W-1:0] out_char;

  sbda_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  sbda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  sbda_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_char),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_char};

endmodule

// ===== design/sbda_checker.sv =====
module sbda_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import sbda_pkg::*;

  localparam logic [7:0] MINUS_CODE = {2'b00, CHAR_MINUS};
  localparam logic [7:0] ZERO_CODE  = {2'b00, CHAR_ZERO};
  localparam logic [7:0] NINE_CODE  = ZERO_CODE + 8'd9;

  // a stalled transaction holds its character and mark
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == MINUS_CODE) ||
                   ((out_tdata >= ZERO_CODE) && (out_tdata <= NINE_CODE)))
    else $error("output character is not a minus sign or a digit");

  // a minus sign is always followed by at least one digit
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == MINUS_CODE) |-> !out_tlast)
    else $error("minus sign marked as last character");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind signed_binary_to_decimal_ascii_core sbda_checker u_sbda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== test/tb.sv =====
module tb;
  import sbda_pkg::*;

  localparam int RADIX      = 10;
  localparam int STALL_LIM  = 2000;  // cycles with no transaction before giving up
  localparam int TAIL_WAIT  = 60;    // longer than one conversion

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } dec_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [5:0] character, [7:6] zero
  logic        out_tlast;

  dec_char_t pending_chars[$];
  int        err_cnt    = 0;
  int        nums_sent  = 0;
  int        negs_sent  = 0;
  int        chars_seen = 0;
  int        idle_cnt   = 0;
  int        sink_hold  = 0;
  bit        src_idle_en  = 1'b1;
  bit        sink_idle_en = 1'b1;
  bit        sink_heavy   = 1'b0;

  signed_binary_to_decimal_ascii_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit heavy);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10 || (heavy && r < 40)) return $urandom_range(15, 60);
    if (r < 45) return 0;
    return $urandom_range(1, 3);
  endfunction

  // decimal text of a two's complement value, most significant character first
  function automatic void predict_text(input logic [31:0] v);
    logic [31:0] mag;
    digit_t      digs[$];
    dec_char_t   c;
    mag = v[31] ? (32'd0 - v) : v;
    do begin
      digs.push_front(digit_t'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (v[31]) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    foreach (digs[i]) begin
      c.code = CHAR_ZERO + {2'b00, digs[i]};
      c.last = (i == digs.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // random value: a quarter fully random bits, the rest spread over digit counts
  function automatic logic [31:0] rand_value();
    longint      lo;
    longint      hi;
    longint      mag;
    int          nd;
    bit          neg;
    logic [31:0] m32;
    if ($urandom_range(0, 3) == 0) return $urandom();
    nd  = $urandom_range(1, 10);
    neg = $urandom_range(0, 1);
    hi  = 1;
    repeat (nd) hi = hi * RADIX;
    lo  = (nd == 1) ? 0 : hi / RADIX;
    hi  = hi - 1;
    if (nd == 10) hi = neg ? 64'd2147483648 : 64'd2147483647;
    mag = lo + (longint'($urandom) % (hi - lo + 1));
    m32 = mag[31:0];
    return neg ? (32'd0 - m32) : m32;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = src_idle_en ? pick_gap(1'b0) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = v;
    do @(posedge clk); while (!in_tready);
    predict_text(v);
    nums_sent++;
    if (v[31]) negs_sent++;
    @(negedge clk);
  endtask

  task automatic test_extremes();
    logic [31:0] vals[] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999_999_999,
      32'd1_000_000_000, -32'sd1_000_000_000, -32'sd99_999, 32'd123_456_789,
      32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd5
    };
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_digit_lengths();
    repeat (76) send_value(rand_value());
  endtask

  // no gaps on either side, so the input queue fills while the converter works
  task automatic test_streaming();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (12) send_value(rand_value());
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_output_stalls();
    src_idle_en = 1'b0;
    sink_heavy  = 1'b1;
    repeat (12) send_value(rand_value());
    src_idle_en = 1'b1;
    sink_heavy  = 1'b0;
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready = 1'b0;
      sink_hold--;
    end else begin
      out_tready = 1'b1;
      if (sink_idle_en && $urandom_range(0, 3) == 0) sink_hold = pick_gap(sink_heavy);
    end
  end

  always @(posedge clk) begin
    dec_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transaction, tdata 0x%02h tlast %b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pending_chars.pop_front();
        chars_seen++;
        if (out_tdata !== {2'b00, want.code}) begin
          err_cnt++;
          $display("%0t: character mismatch, expected 0x%02h, got 0x%02h",
                   $time, {2'b00, want.code}, out_tdata);
        end
        if (out_tlast !== want.last) begin
          err_cnt++;
          $display("%0t: tlast mismatch, expected %b, got %b",
                   $time, want.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= STALL_LIM) begin
      $display("%0t: watchdog, no transaction for %0d cycles, %0d characters owed",
               $time, idle_cnt, pending_chars.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_digit_lengths();
    test_streaming();
    test_output_stalls();
    in_tvalid = 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("converted %0d numbers (%0d negative), %0d characters checked,",
             nums_sent, negs_sent, chars_seen);
    $display("with random gaps, back-to-back streaming and long output stalls");
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sbda_pkg.sv
design/sbda_front.sv
design/sbda_queue.sv
design/sbda_back.sv
design/signed_binary_to_decimal_ascii_core.sv
design/sbda_checker.sv
test/tb.sv
